// ===== design/cbvp_pkg.sv =====
// shared types, widths, constants and helpers of the balance controller
package cbvp_pkg;

  // field widths
  localparam int ANGLE_W  = 15;
  localparam int GAIN_W   = 16;
  localparam int CNT_W    = 16;
  localparam int DUTY_W   = 13;
  localparam int CFG_IDX_W = 3;

  // internal value widths
  localparam int AERR_W   = 16;
  localparam int ADIFF_W  = 17;
  localparam int RERR_W   = 25;
  localparam int RDIFF_W  = 26;
  localparam int RSUM_W   = 21;
  localparam int SERR_W   = 18;
  localparam int SSUM_W   = 15;
  localparam int OUT16_W  = 16;
  localparam int DRIVE_W  = 17;
  localparam int MOTOR_W  = 14;

  // multiply-accumulate widths
  localparam int OPND_W   = 26;
  localparam int PROD_W   = GAIN_W + OPND_W;
  localparam int ACC_W    = 44;

  // limits and offsets
  localparam int RATE_SUM_LIMIT  = 640000;
  localparam int SPEED_SUM_LIMIT = 10000;
  localparam int DRIVE_LIMIT     = 6900;
  localparam int WHEEL_TRIM      = 18;
  localparam int DUTY_OFFSET     = 1100;
  localparam int SAT16_MAX       = 32767;
  localparam int SAT16_MIN       = -32768;

  // fraction shifts
  localparam int ANGLE_SHIFT = 8;
  localparam int RATE_SHIFT  = 14;
  localparam int SPEED_SHIFT = 8;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_ANGLE     = 3'd0,
    CFG_ANGLE_PROP_GAIN  = 3'd1,
    CFG_ANGLE_DIFF_GAIN  = 3'd2,
    CFG_RATE_PROP_GAIN   = 3'd3,
    CFG_RATE_INTEG_GAIN  = 3'd4,
    CFG_RATE_DIFF_GAIN   = 3'd5,
    CFG_SPEED_PROP_GAIN  = 3'd6,
    CFG_SPEED_INTEG_GAIN = 3'd7
  } cfg_idx_t;

  // request from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic                     issue;
    logic                     clear;
    logic signed [GAIN_W-1:0] gain;
    logic signed [OPND_W-1:0] opnd;
  } mac_req_t;

  // arithmetic shift right that rounds toward zero
  function automatic logic signed [ACC_W-1:0] trunc_shr(input logic signed [ACC_W-1:0] v,
                                                         input int s);
    logic signed [ACC_W-1:0] bias;
    logic signed [ACC_W-1:0] sum;
    bias = v[ACC_W-1] ? ((ACC_W'(1) << s) - ACC_W'(1)) : '0;
    sum  = v + bias;
    return sum >>> s;
  endfunction

  // saturate to a signed 16-bit value
  function automatic logic signed [OUT16_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [OUT16_W-1:0] r;
    if (v > ACC_W'(SAT16_MAX)) begin
      r = OUT16_W'(SAT16_MAX);
    end else if (v < ACC_W'(SAT16_MIN)) begin
      r = OUT16_W'(SAT16_MIN);
    end else begin
      r = OUT16_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== design/cbvp_mac.sv =====
// shared signed multiplier with product register and accumulator
module cbvp_mac import cbvp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_req_t                req,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;

  // multiply stage
  always_ff @(posedge clk) begin
    prod <= PROD_W'(req.gain) * PROD_W'(req.opnd);
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= req.issue;
    end
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (req.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

// ===== design/cbvp_wheel.sv =====
// maps a signed wheel drive to forward and reverse compare values
module cbvp_wheel import cbvp_pkg::*; (
  input  logic signed [MOTOR_W-1:0] motor,
  output logic        [DUTY_W-1:0]  fwd,
  output logic        [DUTY_W-1:0]  rev
);

  logic signed [MOTOR_W:0] fwd_sum;
  logic signed [MOTOR_W:0] rev_sum;

  // offset by the dead band in the active direction
  always_comb begin
    fwd_sum = (MOTOR_W+1)'(DUTY_OFFSET) + (MOTOR_W+1)'(motor);
    rev_sum = (MOTOR_W+1)'(DUTY_OFFSET) - (MOTOR_W+1)'(motor);
    if (motor > MOTOR_W'(0)) begin
      fwd = fwd_sum[DUTY_W-1:0];
      rev = '0;
    end else begin
      fwd = '0;
      rev = rev_sum[DUTY_W-1:0];
    end
  end

endmodule

// ===== design/cascade_balance_velocity_pid.sv =====
// top level: cascaded angle/rate pid with velocity pi on one shared multiplier
//
// One request on the input channel (in_valid/in_ready) carries one control tick:
// tilt angle, gyro rate, both encoder counts and the speed target. It yields one
// request on the output channel (out_valid/out_ready) with the forward and
// reverse compare values of both wheels.
// in_ready is high only while the sequencer is idle, so a new tick is taken only
// once the previous one has been written to the output register. A tick runs
// through the single multiplier, which works through seven products in turn,
// each followed by its accumulation, plus the error, rounding and clamping
// steps around them. The result sits in the output register; the next tick may
// be accepted while it waits, and the sequencer holds in its last step if the
// receiver still has not taken the previous result.
// Gains and the target angle are written over cfg_valid/cfg_index/cfg_data; the
// user must write them only while idle, which the block itself does not enforce;
// cfg_ready is always high.
// Reset (rst, synchronous) loads the default gains and target angle and clears
// all loop memory: previous errors and both integrators.
module cascade_balance_velocity_pid import cbvp_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic        [CFG_IDX_W-1:0] cfg_index,
  input  logic        [GAIN_W-1:0]    cfg_data,
  // tick input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [ANGLE_W-1:0]   tilt_angle,
  input  logic signed [CNT_W-1:0]     tilt_rate,
  input  logic signed [CNT_W-1:0]     left_count,
  input  logic signed [CNT_W-1:0]     right_count,
  input  logic signed [CNT_W-1:0]     speed_target,
  // drive output
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic        [DUTY_W-1:0]    right_fwd_duty,
  output logic        [DUTY_W-1:0]    right_rev_duty,
  output logic        [DUTY_W-1:0]    left_fwd_duty,
  output logic        [DUTY_W-1:0]    left_rev_duty
);

  typedef enum logic [4:0] {
    S_IDLE, S_ERR, S_A0, S_A1, S_AW, S_AIM, S_RERR, S_R0, S_R1, S_R2, S_RW,
    S_BAL, S_V0, S_V1, S_VW, S_VEL, S_DRV, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic signed [ANGLE_W-1:0] target_angle;
  logic signed [GAIN_W-1:0]  angle_prop_gain;
  logic signed [GAIN_W-1:0]  angle_diff_gain;
  logic signed [GAIN_W-1:0]  rate_prop_gain;
  logic signed [GAIN_W-1:0]  rate_integ_gain;
  logic signed [GAIN_W-1:0]  rate_diff_gain;
  logic signed [GAIN_W-1:0]  speed_prop_gain;
  logic signed [GAIN_W-1:0]  speed_integ_gain;

  // loop memory
  logic signed [AERR_W-1:0]  prev_angle_error;
  logic signed [RERR_W-1:0]  prev_rate_error;
  logic signed [RSUM_W-1:0]  rate_error_sum;
  logic signed [SSUM_W-1:0]  speed_error_sum;

  // captured tick and intermediate values
  logic signed [ANGLE_W-1:0] angle_meas;
  logic signed [CNT_W-1:0]   rate_meas;
  logic signed [CNT_W-1:0]   left_meas;
  logic signed [CNT_W-1:0]   right_meas;
  logic signed [CNT_W-1:0]   speed_tgt;
  logic signed [AERR_W-1:0]  angle_err;
  logic signed [ADIFF_W-1:0] angle_diff;
  logic signed [SERR_W-1:0]  speed_err;
  logic signed [RERR_W-1:0]  aim_rate;
  logic signed [RERR_W-1:0]  rate_err;
  logic signed [RDIFF_W-1:0] rate_diff;
  logic signed [OUT16_W-1:0] balance;
  logic signed [OUT16_W-1:0] vel;
  logic signed [MOTOR_W-1:0] motor_left;
  logic signed [MOTOR_W-1:0] motor_right;

  // combinational step results
  logic signed [AERR_W-1:0]   angle_err_next;
  logic signed [ADIFF_W-1:0]  angle_diff_next;
  logic signed [SERR_W-1:0]   speed_err_next;
  logic signed [SSUM_W+3:0]   ssum_raw;
  logic signed [SSUM_W-1:0]   speed_error_sum_next;
  logic signed [RERR_W-1:0]   rate_err_next;
  logic signed [RDIFF_W-1:0]  rate_diff_next;
  logic signed [RDIFF_W-1:0]  rsum_raw;
  logic signed [RSUM_W-1:0]   rate_error_sum_next;
  logic signed [DRIVE_W-1:0]  drive;
  logic signed [DRIVE_W:0]    left_raw;
  logic signed [DRIVE_W:0]    right_raw;
  logic signed [MOTOR_W-1:0]  motor_left_next;
  logic signed [MOTOR_W-1:0]  motor_right_next;
  logic        [DUTY_W-1:0]   rfwd;
  logic        [DUTY_W-1:0]   rrev;
  logic        [DUTY_W-1:0]   lfwd;
  logic        [DUTY_W-1:0]   lrev;

  mac_req_t                   mac_req;
  logic signed [ACC_W-1:0]    acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_angle     <= ANGLE_W'(397);
      angle_prop_gain  <= GAIN_W'(1024);
      angle_diff_gain  <= GAIN_W'(0);
      rate_prop_gain   <= GAIN_W'(-9216);
      rate_integ_gain  <= GAIN_W'(-1075);
      rate_diff_gain   <= GAIN_W'(3584);
      speed_prop_gain  <= GAIN_W'(3584);
      speed_integ_gain <= GAIN_W'(102);
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TARGET_ANGLE:     target_angle     <= cfg_data[ANGLE_W-1:0];
        CFG_ANGLE_PROP_GAIN:  angle_prop_gain  <= cfg_data;
        CFG_ANGLE_DIFF_GAIN:  angle_diff_gain  <= cfg_data;
        CFG_RATE_PROP_GAIN:   rate_prop_gain   <= cfg_data;
        CFG_RATE_INTEG_GAIN:  rate_integ_gain  <= cfg_data;
        CFG_RATE_DIFF_GAIN:   rate_diff_gain   <= cfg_data;
        CFG_SPEED_PROP_GAIN:  speed_prop_gain  <= cfg_data;
        CFG_SPEED_INTEG_GAIN: speed_integ_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // angle and speed errors, speed integrator
  always_comb begin
    angle_err_next  = AERR_W'(target_angle) - AERR_W'(angle_meas);
    angle_diff_next = ADIFF_W'(angle_err_next) - ADIFF_W'(prev_angle_error);
    speed_err_next  = SERR_W'(right_meas) - SERR_W'(left_meas) - SERR_W'(speed_tgt);
    ssum_raw        = (SSUM_W+4)'(speed_error_sum) + (SSUM_W+4)'(speed_err_next);
    if (ssum_raw > (SSUM_W+4)'(SPEED_SUM_LIMIT)) begin
      speed_error_sum_next = SSUM_W'(SPEED_SUM_LIMIT);
    end else if (ssum_raw < (SSUM_W+4)'(-SPEED_SUM_LIMIT)) begin
      speed_error_sum_next = SSUM_W'(-SPEED_SUM_LIMIT);
    end else begin
      speed_error_sum_next = SSUM_W'(ssum_raw);
    end
  end

  // rate error and rate integrator
  always_comb begin
    rate_err_next  = RERR_W'(aim_rate) - RERR_W'(rate_meas);
    rate_diff_next = RDIFF_W'(rate_err_next) - RDIFF_W'(prev_rate_error);
    rsum_raw       = RDIFF_W'(rate_error_sum) + RDIFF_W'(rate_err_next);
    if (rsum_raw > RDIFF_W'(RATE_SUM_LIMIT)) begin
      rate_error_sum_next = RSUM_W'(RATE_SUM_LIMIT);
    end else if (rsum_raw < RDIFF_W'(-RATE_SUM_LIMIT)) begin
      rate_error_sum_next = RSUM_W'(-RATE_SUM_LIMIT);
    end else begin
      rate_error_sum_next = RSUM_W'(rsum_raw);
    end
  end

  // motor drive with per-wheel trim and clamp
  always_comb begin
    drive     = DRIVE_W'(balance) - DRIVE_W'(vel);
    left_raw  = (DRIVE_W+1)'(drive) + (DRIVE_W+1)'(WHEEL_TRIM);
    right_raw = (DRIVE_W+1)'(drive) - (DRIVE_W+1)'(WHEEL_TRIM);
    if (left_raw > (DRIVE_W+1)'(DRIVE_LIMIT)) begin
      motor_left_next = MOTOR_W'(DRIVE_LIMIT);
    end else if (left_raw < (DRIVE_W+1)'(-DRIVE_LIMIT)) begin
      motor_left_next = MOTOR_W'(-DRIVE_LIMIT);
    end else begin
      motor_left_next = MOTOR_W'(left_raw);
    end
    if (right_raw > (DRIVE_W+1)'(DRIVE_LIMIT)) begin
      motor_right_next = MOTOR_W'(DRIVE_LIMIT);
    end else if (right_raw < (DRIVE_W+1)'(-DRIVE_LIMIT)) begin
      motor_right_next = MOTOR_W'(-DRIVE_LIMIT);
    end else begin
      motor_right_next = MOTOR_W'(right_raw);
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    mac_req = '0;
    case (state)
      S_ERR, S_AIM, S_BAL: begin
        mac_req.clear = 1'b1;
      end
      S_A0: begin
        mac_req.issue = 1'b1;
        mac_req.gain  = angle_prop_gain;
        mac_req.opnd  = OPND_W'(angle_err);
      end
      S_A1: begin
        mac_req.issue = 1'b1;
        mac_req.gain  = angle_diff_gain;
        mac_req.opnd  = OPND_W'(angle_diff);
      end
      S_R0: begin
        mac_req.issue = 1'b1;
        mac_req.gain  = rate_prop_gain;
        mac_req.opnd  = OPND_W'(rate_err);
      end
      S_R1: begin
        mac_req.issue = 1'b1;
        mac_req.gain  = rate_integ_gain;
        mac_req.opnd  = OPND_W'(rate_error_sum);
      end
      S_R2: begin
        mac_req.issue = 1'b1;
        mac_req.gain  = rate_diff_gain;
        mac_req.opnd  = OPND_W'(rate_diff);
      end
      S_V0: begin
        mac_req.issue = 1'b1;
        mac_req.gain  = speed_prop_gain;
        mac_req.opnd  = OPND_W'(speed_err);
      end
      S_V1: begin
        mac_req.issue = 1'b1;
        mac_req.gain  = speed_integ_gain;
        mac_req.opnd  = OPND_W'(speed_error_sum);
      end
      default: ;
    endcase
  end

  cbvp_mac u_mac (
    .clk (clk),
    .rst (rst),
    .req (mac_req),
    .acc (acc)
  );

  cbvp_wheel u_wheel_right (
    .motor (motor_right),
    .fwd   (rfwd),
    .rev   (rrev)
  );

  cbvp_wheel u_wheel_left (
    .motor (motor_left),
    .fwd   (lfwd),
    .rev   (lrev)
  );

  // sequencer, loop memory and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      prev_angle_error <= '0;
      prev_rate_error  <= '0;
      rate_error_sum   <= '0;
      speed_error_sum  <= '0;
    end else begin
      // the final step reloads the output register itself
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            angle_meas <= tilt_angle;
            rate_meas  <= tilt_rate;
            left_meas  <= left_count;
            right_meas <= right_count;
            speed_tgt  <= speed_target;
            state      <= S_ERR;
          end
        end
        S_ERR: begin
          angle_err        <= angle_err_next;
          angle_diff       <= angle_diff_next;
          prev_angle_error <= angle_err_next;
          speed_err        <= speed_err_next;
          speed_error_sum  <= speed_error_sum_next;
          state            <= S_A0;
        end
        S_A0: state <= S_A1;
        S_A1: state <= S_AW;
        S_AW: state <= S_AIM;
        S_AIM: begin
          aim_rate <= RERR_W'(trunc_shr(acc, ANGLE_SHIFT));
          state    <= S_RERR;
        end
        S_RERR: begin
          rate_err        <= rate_err_next;
          rate_diff       <= rate_diff_next;
          prev_rate_error <= rate_err_next;
          rate_error_sum  <= rate_error_sum_next;
          state           <= S_R0;
        end
        S_R0: state <= S_R1;
        S_R1: state <= S_R2;
        S_R2: state <= S_RW;
        S_RW: state <= S_BAL;
        S_BAL: begin
          balance <= sat16(trunc_shr(acc, RATE_SHIFT));
          state   <= S_V0;
        end
        S_V0: state <= S_V1;
        S_V1: state <= S_VW;
        S_VW: state <= S_VEL;
        S_VEL: begin
          vel   <= sat16(trunc_shr(acc, SPEED_SHIFT));
          state <= S_DRV;
        end
        S_DRV: begin
          motor_left  <= motor_left_next;
          motor_right <= motor_right_next;
          state       <= S_OUT;
        end
        S_OUT: begin
          // wait here while the previous result is still unclaimed
          if (!out_valid || out_ready) begin
            right_fwd_duty <= rfwd;
            right_rev_duty <= rrev;
            left_fwd_duty  <= lfwd;
            left_rev_duty  <= lrev;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a tick is in progress");

  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (right_fwd_duty == '0 || right_rev_duty == '0) &&
                  (left_fwd_duty == '0 || left_rev_duty == '0))
    else $error("wheel driven in both directions");

  a_rate_sum_bound: assert property (@(posedge clk) disable iff (rst)
    (rate_error_sum <= RSUM_W'(RATE_SUM_LIMIT)) &&
    (rate_error_sum >= RSUM_W'(-RATE_SUM_LIMIT)))
    else $error("rate integrator outside its clamp");

  a_result_from_last_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside the final step");

endmodule
